@@ rtl/sno_pkg.sv @@
// Shared types, constants and gradient helpers for the octave simplex noise block.
package sno_pkg;

    localparam int PERM_ENTRIES = 256;
    localparam int PERM_W       = 8;
    localparam int PERM_AW      = $clog2(PERM_ENTRIES);
    localparam int MAX_OCTAVES  = 8;
    localparam int OCT_W        = 4;
    localparam int COORD_BITS   = 32;
    localparam int FREQ_W       = 32;
    localparam int AMP_W        = 26;
    localparam int FSTEP_W      = 27;
    localparam int ASTEP_W      = 18;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int NOISE_W      = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam int FX_ONE      = 65536;
    localparam int FX_HALF     = 32768;
    localparam int SKEW_F2     = 23988;
    localparam int UNSKEW_G2   = 13849;
    localparam int NOISE_SCALE = 43;

    localparam logic [FREQ_W-1:0] BASE_FREQ_RESET = 32'd16777216;
    localparam logic [AMP_W-1:0]  BASE_AMP_RESET  = 26'd65536;
    localparam logic [OCT_W-1:0]  OCT_RESET       = 4'd1;
    localparam logic [FSTEP_W-1:0] FSTEP_RESET    = 27'd33554432;
    localparam logic [ASTEP_W-1:0] ASTEP_RESET    = 18'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FREQUENCY = 3'd0,
        CFG_BASE_AMPLITUDE = 3'd1,
        CFG_OCTAVE_COUNT   = 3'd2,
        CFG_FREQUENCY_STEP = 3'd3,
        CFG_AMPLITUDE_STEP = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                          command;
        logic [PERM_W-1:0]             perm_index;
        logic [PERM_W-1:0]             perm_value;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_z;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  base_frequency;
        logic [AMP_W-1:0]   base_amplitude;
        logic [OCT_W-1:0]   octave_count;
        logic [FSTEP_W-1:0] frequency_step;
        logic [ASTEP_W-1:0] amplitude_step;
    } cfg_t;

    // Hash modulo 12: fold the high nibble (16 = 4 mod 12), then three conditional subtracts
    function automatic logic [3:0] mod12(input logic [PERM_W-1:0] h);
        logic [6:0] v;
        v = {1'b0, h[7:4], 2'b00} + {3'b000, h[3:0]};
        if (v >= 7'd48) v = v - 7'd48;
        if (v >= 7'd24) v = v - 7'd24;
        if (v >= 7'd12) v = v - 7'd12;
        return v[3:0];
    endfunction

    // Dot product with one of the twelve gradient directions
    function automatic logic signed [19:0] grad_dot(input logic [3:0] r,
                                                    input logic signed [18:0] dx,
                                                    input logic signed [18:0] dy);
        logic signed [19:0] ex;
        logic signed [19:0] ey;
        logic signed [19:0] dot;
        ex = 20'(dx);
        ey = 20'(dy);
        case (r)
            4'd0:    dot = ex + ey;
            4'd1:    dot = ey - ex;
            4'd2:    dot = ex - ey;
            4'd3:    dot = -ex - ey;
            4'd4:    dot = ex;
            4'd5:    dot = -ex;
            4'd6:    dot = ex;
            4'd7:    dot = -ex;
            4'd8:    dot = ey;
            4'd9:    dot = -ey;
            4'd10:   dot = ey;
            4'd11:   dot = -ey;
            default: dot = '0;
        endcase
        return dot;
    endfunction

endpackage

@@ rtl/sno_ram.sv @@
// Generic single-port RAM with registered read.
module sno_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sno_front.sv @@
// Front end: command acceptance and the item queue ahead of the evaluation engine.
module sno_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sno_pkg::item_t  in_item,
    input  logic            pop,
    output logic            head_valid,
    output sno_pkg::item_t  head
);
    import sno_pkg::*;

    item_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push;
    logic                take;

    assign busy       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push       = start && !busy;
    assign head_valid = (count_reg != '0);
    assign take       = pop && head_valid;
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, take})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_ptr_gap_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH)) |->
            (QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0]))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/sno_back.sv @@
// Back end: permutation table, per-octave simplex sequencer and final normalising divide.
module sno_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  sno_pkg::item_t                    head,
    output logic                              pop,
    input  sno_pkg::cfg_t                     cfg,
    output logic                              result_valid,
    output logic [sno_pkg::NOISE_W-1:0]       noise_value,
    output logic                              degenerate
);
    import sno_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_SCALE_X = 16'h0002,
        ST_SCALE_Z = 16'h0004,
        ST_SKEW    = 16'h0008,
        ST_LATTICE = 16'h0010,
        ST_UNSKEW  = 16'h0020,
        ST_READ    = 16'h0040,
        ST_SQ      = 16'h0080,
        ST_T1      = 16'h0100,
        ST_T2      = 16'h0200,
        ST_DOT     = 16'h0400,
        ST_NOISE   = 16'h0800,
        ST_ACC     = 16'h1000,
        ST_STEP    = 16'h2000,
        ST_FINAL   = 16'h4000,
        ST_DIV     = 16'h8000
    } state_t;

    localparam logic signed [43:0] CLAMP_HI = 44'(2 * FX_ONE);
    localparam logic signed [43:0] CLAMP_LO = -44'(2 * FX_ONE);

    function automatic logic signed [18:0] clamp2(input logic signed [43:0] v);
        logic signed [18:0] r;
        if (v > CLAMP_HI)
            r = 19'(CLAMP_HI);
        else if (v < CLAMP_LO)
            r = 19'(CLAMP_LO);
        else
            r = v[18:0];
        return r;
    endfunction

    state_t                    state_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic [AMP_W-1:0]          amp_reg;
    logic [OCT_W-1:0]          count_reg;
    logic [OCT_W-1:0]          oct_reg;
    logic signed [59:0]        total_reg;
    logic [28:0]               asum_reg;
    logic signed [39:0]        sx_reg;
    logic signed [39:0]        sz_reg;
    logic signed [40:0]        skew_reg;
    logic signed [25:0]        i_reg;
    logic signed [25:0]        j_reg;
    logic signed [43:0]        x0_reg;
    logic signed [43:0]        y0_reg;
    logic                      i1_reg;
    logic [2:0]                rd_step_reg;
    logic [PERM_W-1:0]         a0_reg;
    logic [PERM_W-1:0]         a1_reg;
    logic [PERM_W-1:0]         a2_reg;
    logic [PERM_W-1:0]         h0_reg;
    logic [PERM_W-1:0]         h1_reg;
    logic [PERM_W-1:0]         h2_reg;
    logic [1:0]                corner_reg;
    logic signed [18:0]        dx_reg;
    logic signed [18:0]        dy_reg;
    logic signed [20:0]        t_reg;
    logic signed [35:0]        csum_reg;
    logic signed [26:0]        n_reg;
    logic [45:0]               rem_reg;
    logic [45:0]               dsh_reg;
    logic [NOISE_W-1:0]        q_reg;
    logic [3:0]                dstep_reg;
    logic                      result_valid_reg;
    logic [NOISE_W-1:0]        noise_reg;
    logic                      degenerate_reg;

    logic signed [COORD_BITS-1:0] coord_sel;
    logic signed [63:0]        scale_prod;
    logic signed [40:0]        ssum;
    logic signed [56:0]        skew_prod;
    logic signed [41:0]        xs;
    logic signed [41:0]        zs;
    logic signed [26:0]        ij;
    logic signed [41:0]        unskew;
    logic signed [43:0]        x0_next;
    logic signed [43:0]        y0_next;
    logic signed [43:0]        off_x;
    logic signed [43:0]        off_y;
    logic signed [18:0]        dxc;
    logic signed [18:0]        dyc;
    logic signed [37:0]        sq;
    logic signed [20:0]        t_next;
    logic [31:0]               tsq;
    logic signed [20:0]        tsq_next;
    logic [PERM_W-1:0]         h_sel;
    logic signed [19:0]        dot;
    logic signed [33:0]        contrib;
    logic signed [42:0]        noise_prod;
    logic signed [53:0]        acc_prod;
    logic [58:0]               freq_prod;
    logic [FREQ_W-1:0]         freq_next;
    logic [43:0]               amp_prod;
    logic [AMP_W-1:0]          amp_next;
    logic signed [60:0]        num;
    logic [29:0]               dd;
    logic [45:0]               lim;
    logic                      ge;
    logic [NOISE_W-1:0]        q_next;
    logic [OCT_W-1:0]          count_next;
    logic [PERM_AW-1:0]        rd_addr;
    logic [PERM_AW-1:0]        ram_addr;
    logic                      ram_we;
    logic [PERM_W-1:0]         ram_rdata;

    assign pop    = head_valid && (state_reg == ST_IDLE);
    assign ram_we = pop && (head.command == CMD_LOAD);

    always_comb
    begin
        coord_sel  = (state_reg == ST_SCALE_X) ? x_reg : z_reg;
        scale_prod = 64'(coord_sel) * 64'($signed({1'b0, freq_reg}));

        ssum      = 41'(sx_reg) + 41'(sz_reg);
        skew_prod = 57'(ssum) * 57'(SKEW_F2);

        xs = 42'(sx_reg) + 42'(skew_reg);
        zs = 42'(sz_reg) + 42'(skew_reg);

        ij      = 27'(i_reg) + 27'(j_reg);
        unskew  = 42'(ij) * 42'(UNSKEW_G2);
        x0_next = 44'(sx_reg) - (44'(i_reg) <<< 16) + 44'(unskew);
        y0_next = 44'(sz_reg) - (44'(j_reg) <<< 16) + 44'(unskew);

        case (corner_reg)
            2'd0:
            begin
                off_x = x0_reg;
                off_y = y0_reg;
                h_sel = h0_reg;
            end
            2'd1:
            begin
                off_x = x0_reg - (i1_reg ? 44'(FX_ONE) : 44'sd0) + 44'(UNSKEW_G2);
                off_y = y0_reg - (i1_reg ? 44'sd0 : 44'(FX_ONE)) + 44'(UNSKEW_G2);
                h_sel = h1_reg;
            end
            default:
            begin
                off_x = x0_reg - 44'(FX_ONE) + 44'(2 * UNSKEW_G2);
                off_y = y0_reg - 44'(FX_ONE) + 44'(2 * UNSKEW_G2);
                h_sel = h2_reg;
            end
        endcase

        dxc    = clamp2(off_x);
        dyc    = clamp2(off_y);
        sq     = 38'(dxc) * 38'(dxc) + 38'(dyc) * 38'(dyc);
        t_next = 21'(FX_HALF) - $signed({1'b0, sq[35:16]});

        tsq      = t_reg[15:0] * t_reg[15:0];
        tsq_next = $signed({5'b00000, tsq[31:16]});

        dot        = grad_dot(mod12(h_sel), dx_reg, dy_reg);
        contrib    = 34'($signed({1'b0, t_reg[12:0]})) * 34'(dot);
        noise_prod = 43'(csum_reg) * 43'(NOISE_SCALE);
        acc_prod   = 54'(n_reg) * 54'($signed({1'b0, amp_reg}));

        freq_prod = 59'(freq_reg) * 59'(cfg.frequency_step);
        freq_next = (freq_prod[58:56] != 3'b000) ? '1 : freq_prod[55:24];
        amp_prod  = 44'(amp_reg) * 44'(cfg.amplitude_step);
        amp_next  = (amp_prod[43:42] != 2'b00) ? '1 : amp_prod[41:16];

        num = 61'(total_reg) + $signed(61'({asum_reg, 16'h0000}))
            + $signed(61'(asum_reg));
        dd  = {asum_reg, 1'b0};
        lim = {dd, 16'h0000};

        ge     = (rem_reg >= dsh_reg);
        q_next = {q_reg[NOISE_W-2:0], ge};

        count_next = (cfg.octave_count > OCT_W'(MAX_OCTAVES)) ?
                     OCT_W'(MAX_OCTAVES) : cfg.octave_count;

        case (rd_step_reg)
            3'd0:    rd_addr = i_reg[PERM_AW-1:0];
            3'd1:    rd_addr = i_reg[PERM_AW-1:0] + PERM_AW'(i1_reg);
            3'd2:    rd_addr = i_reg[PERM_AW-1:0] + 1'b1;
            3'd3:    rd_addr = a0_reg + j_reg[PERM_AW-1:0];
            3'd4:    rd_addr = a1_reg + j_reg[PERM_AW-1:0] + PERM_AW'(!i1_reg);
            3'd5:    rd_addr = a2_reg + j_reg[PERM_AW-1:0] + 1'b1;
            default: rd_addr = '0;
        endcase

        ram_addr = (state_reg == ST_IDLE) ? head.perm_index : rd_addr;
    end

    sno_ram #(
        .WIDTH (PERM_W),
        .DEPTH (PERM_ENTRIES)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.perm_value),
        .rdata (ram_rdata)
    );

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg     <= head.coord_x;
                z_reg     <= head.coord_z;
                freq_reg  <= cfg.base_frequency;
                amp_reg   <= cfg.base_amplitude;
                total_reg <= '0;
                asum_reg  <= '0;
            end
            ST_SCALE_X: sx_reg   <= scale_prod[63:24];
            ST_SCALE_Z: sz_reg   <= scale_prod[63:24];
            ST_SKEW:    skew_reg <= skew_prod[56:16];
            ST_LATTICE:
            begin
                i_reg <= xs[41:16];
                j_reg <= zs[41:16];
            end
            ST_UNSKEW:
            begin
                x0_reg <= x0_next;
                y0_reg <= y0_next;
                i1_reg <= (x0_next > y0_next);
            end
            ST_READ:
            begin
                case (rd_step_reg)
                    3'd1:    a0_reg <= ram_rdata;
                    3'd2:    a1_reg <= ram_rdata;
                    3'd3:    a2_reg <= ram_rdata;
                    3'd4:    h0_reg <= ram_rdata;
                    3'd5:    h1_reg <= ram_rdata;
                    3'd6:    h2_reg <= ram_rdata;
                    default: a0_reg <= a0_reg;
                endcase
                csum_reg <= '0;
            end
            ST_SQ:
            begin
                dx_reg <= dxc;
                dy_reg <= dyc;
                t_reg  <= t_next;
            end
            // A corner outside the falloff radius contributes nothing
            ST_T1:    t_reg    <= (t_reg <= 21'sd0) ? 21'sd0 : tsq_next;
            ST_T2:    t_reg    <= tsq_next;
            ST_DOT:   csum_reg <= csum_reg + 36'(contrib);
            ST_NOISE: n_reg    <= noise_prod[42:16];
            ST_ACC:
            begin
                total_reg <= total_reg + 60'(acc_prod);
                asum_reg  <= asum_reg + 29'(amp_reg);
                freq_reg  <= freq_next;
            end
            ST_STEP:  amp_reg  <= amp_next;
            ST_FINAL:
            begin
                rem_reg <= num[45:0];
                dsh_reg <= 46'({dd, 15'h0000});
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? (rem_reg - dsh_reg) : rem_reg;
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
            end
            default: q_reg <= q_reg;
        endcase
    end

    // Sequencer and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            oct_reg          <= '0;
            rd_step_reg      <= '0;
            corner_reg       <= '0;
            dstep_reg        <= '0;
            result_valid_reg <= 1'b0;
            noise_reg        <= '0;
            degenerate_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && (head.command == CMD_EVAL))
                    begin
                        count_reg <= count_next;
                        oct_reg   <= '0;
                        state_reg <= (count_next == '0) ? ST_FINAL : ST_SCALE_X;
                    end
                end
                ST_SCALE_X: state_reg <= ST_SCALE_Z;
                ST_SCALE_Z: state_reg <= ST_SKEW;
                ST_SKEW:    state_reg <= ST_LATTICE;
                ST_LATTICE: state_reg <= ST_UNSKEW;
                ST_UNSKEW:
                begin
                    rd_step_reg <= '0;
                    state_reg   <= ST_READ;
                end
                ST_READ:
                begin
                    rd_step_reg <= rd_step_reg + 1'b1;
                    if (rd_step_reg == 3'd6)
                    begin
                        corner_reg <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: state_reg <= ST_T1;
                ST_T1: state_reg <= ST_T2;
                ST_T2: state_reg <= ST_DOT;
                ST_DOT:
                begin
                    corner_reg <= corner_reg + 1'b1;
                    state_reg  <= (corner_reg == 2'd2) ? ST_NOISE : ST_SQ;
                end
                ST_NOISE: state_reg <= ST_ACC;
                ST_ACC:   state_reg <= ST_STEP;
                ST_STEP:
                begin
                    oct_reg   <= oct_reg + 1'b1;
                    state_reg <= ((oct_reg + 1'b1) == count_reg) ? ST_FINAL : ST_SCALE_X;
                end
                ST_FINAL:
                begin
                    dstep_reg <= '0;
                    if (asum_reg == '0)
                    begin
                        noise_reg        <= NOISE_W'(FX_HALF);
                        degenerate_reg   <= 1'b1;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else if (num <= 61'sd0)
                    begin
                        noise_reg        <= '0;
                        degenerate_reg   <= 1'b0;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else if ((num[60:46] != '0) || (num[45:0] >= lim))
                    begin
                        noise_reg        <= '1;
                        degenerate_reg   <= 1'b0;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 4'd15)
                    begin
                        noise_reg        <= q_next;
                        degenerate_reg   <= 1'b0;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign noise_value  = noise_reg;
    assign degenerate   = degenerate_reg;

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ($past(state_reg) == ST_FINAL || $past(state_reg) == ST_DIV))
        else $error("result strobe without a finishing step");

    a_octave_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE_X || state_reg == ST_STEP) |-> (oct_reg < count_reg))
        else $error("octave counter past octave count");

    a_div_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of bound");

endmodule

@@ rtl/simplex_noise_2d_octaves.sv @@
// Top level: configuration registers, front-end queue and octave noise engine.
//
// Pulse start with a command while busy is low. A load (command 0) writes one
// permutation entry; every entry an evaluation reads must have been loaded
// first. An evaluation (command 1) produces exactly one result, shown for a
// single cycle with result_valid high; the receiver cannot stall it. Up to four
// commands queue ahead of the engine, so busy rises only when that queue is
// full. One evaluation occupies the engine for its accept step, the per-octave
// sequence for each octave and, unless the result is clamped or degenerate, the
// closing divide, and then its result strobes. The engine's pace is set by the
// single-port permutation RAM (six hash reads per octave) and the sequencer,
// which steps through its states one at a time.
// Configuration writes are always ready and must only be made while idle.
module simplex_noise_2d_octaves (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic [sno_pkg::PERM_W-1:0]           perm_index,
    input  logic [sno_pkg::PERM_W-1:0]           perm_value,
    input  logic signed [sno_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [sno_pkg::COORD_BITS-1:0] coord_z,
    output logic                                 result_valid,
    output logic [sno_pkg::NOISE_W-1:0]          noise_value,
    output logic                                 degenerate,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sno_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sno_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sno_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    item_t head;
    logic  head_valid;
    logic  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_frequency <= BASE_FREQ_RESET;
            cfg_reg.base_amplitude <= BASE_AMP_RESET;
            cfg_reg.octave_count   <= OCT_RESET;
            cfg_reg.frequency_step <= FSTEP_RESET;
            cfg_reg.amplitude_step <= ASTEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Drop writes to indexes beyond the register list
            case (cfg_index)
                CFG_BASE_FREQUENCY: cfg_reg.base_frequency <= cfg_data[FREQ_W-1:0];
                CFG_BASE_AMPLITUDE: cfg_reg.base_amplitude <= cfg_data[AMP_W-1:0];
                CFG_OCTAVE_COUNT:   cfg_reg.octave_count   <= cfg_data[OCT_W-1:0];
                CFG_FREQUENCY_STEP: cfg_reg.frequency_step <= cfg_data[FSTEP_W-1:0];
                CFG_AMPLITUDE_STEP: cfg_reg.amplitude_step <= cfg_data[ASTEP_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_item.command    = cmd_t'(command);
    assign in_item.perm_index = perm_index;
    assign in_item.perm_value = perm_value;
    assign in_item.coord_x    = coord_x;
    assign in_item.coord_z    = coord_z;

    sno_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_item    (in_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sno_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .noise_value  (noise_value),
        .degenerate   (degenerate)
    );

endmodule

@@ tb/sno_checker.sv @@
// Checker for the octave simplex noise block: predicts every evaluation and compares results.
`timescale 1ns / 100ps

module sno_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  command,
    input  logic [sno_pkg::PERM_W-1:0]            perm_index,
    input  logic [sno_pkg::PERM_W-1:0]            perm_value,
    input  logic signed [sno_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [sno_pkg::COORD_BITS-1:0] coord_z,
    input  logic                                  result_valid,
    input  logic [sno_pkg::NOISE_W-1:0]           noise_value,
    input  logic                                  degenerate,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [sno_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sno_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                    fail_count,
    output int                                    pending
);
    import sno_pkg::*;

    typedef struct packed {
        logic [NOISE_W-1:0] noise;
        logic               degen;
    } noise_result_t;

    localparam longint SCALED_LIMIT = 64'sd140737488355327;
    localparam longint FREQ_LIMIT   = 64'sd4294967295;
    localparam longint AMP_LIMIT    = 64'sd67108863;

    const int grad_x[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    const int grad_y[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

    logic [PERM_W-1:0] perm_copy [PERM_ENTRIES];
    cfg_t              cfg_copy;
    noise_result_t     expected_noise [$];

    assign pending = expected_noise.size();

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int lattice_hash(longint i, longint j);
        int a;
        a = perm_copy[i & 255];
        return perm_copy[(a + (j & 255)) & 255];
    endfunction

    function automatic longint scale_coord(longint c, longint f);
        longint hi;
        longint lo;
        hi = c >>> 24;
        lo = c - hi * 64'sd16777216;
        return clamp(hi * f + ((lo * f) >>> 24), -SCALED_LIMIT, SCALED_LIMIT);
    endfunction

    function automatic longint corner_term(longint dx, longint dy, int h);
        longint t;
        int     g;
        g = h % 12;
        dx = clamp(dx, -2 * FX_ONE, 2 * FX_ONE);
        dy = clamp(dy, -2 * FX_ONE, 2 * FX_ONE);
        t = FX_HALF - ((dx * dx + dy * dy) >>> 16);
        if (t <= 0)
            return 0;
        t = (t * t) >>> 16;
        t = (t * t) >>> 16;
        return t * (grad_x[g] * dx + grad_y[g] * dy);
    endfunction

    function automatic longint simplex_sample(longint x, longint y);
        longint skew;
        longint i;
        longint j;
        longint unskew;
        longint x0;
        longint y0;
        longint i1;
        longint j1;
        longint acc;
        skew = ((x + y) * SKEW_F2) >>> 16;
        i = (x + skew) >>> 16;
        j = (y + skew) >>> 16;
        unskew = (i + j) * UNSKEW_G2;
        x0 = x - i * FX_ONE + unskew;
        y0 = y - j * FX_ONE + unskew;
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        acc = corner_term(x0, y0, lattice_hash(i, j));
        acc += corner_term(x0 - i1 * FX_ONE + UNSKEW_G2, y0 - j1 * FX_ONE + UNSKEW_G2,
                           lattice_hash(i + i1, j + j1));
        acc += corner_term(x0 - FX_ONE + 2 * UNSKEW_G2, y0 - FX_ONE + 2 * UNSKEW_G2,
                           lattice_hash(i + 1, j + 1));
        return (NOISE_SCALE * acc) >>> 16;
    endfunction

    function automatic noise_result_t fbm_noise(longint x, longint z);
        noise_result_t r;
        longint freq;
        longint amp;
        longint total;
        longint asum;
        longint num;
        longint q;
        int     count;
        freq = longint'(cfg_copy.base_frequency);
        amp = longint'(cfg_copy.base_amplitude);
        count = cfg_copy.octave_count > MAX_OCTAVES ? MAX_OCTAVES : cfg_copy.octave_count;
        total = 0;
        asum = 0;
        for (int k = 0; k < count; k++)
        begin
            total += simplex_sample(scale_coord(x, freq), scale_coord(z, freq)) * amp;
            asum += amp;
            freq = clamp((freq * longint'(cfg_copy.frequency_step)) >>> 24, 0, FREQ_LIMIT);
            amp = clamp((amp * longint'(cfg_copy.amplitude_step)) >>> 16, 0, AMP_LIMIT);
        end
        if (asum == 0)
        begin
            r.noise = 16'd32768;
            r.degen = 1'b1;
            return r;
        end
        num = total + asum * FX_ONE + asum;
        q = (num <= 0) ? 0 : clamp(num / (asum * 2), 0, 65535);
        r.noise = q[NOISE_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        noise_result_t exp_r;
        if (!rst_n)
        begin
            cfg_copy.base_frequency <= BASE_FREQ_RESET;
            cfg_copy.base_amplitude <= BASE_AMP_RESET;
            cfg_copy.octave_count   <= OCT_RESET;
            cfg_copy.frequency_step <= FSTEP_RESET;
            cfg_copy.amplitude_step <= ASTEP_RESET;
            expected_noise.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE_FREQUENCY: cfg_copy.base_frequency <= cfg_data[FREQ_W-1:0];
                    CFG_BASE_AMPLITUDE: cfg_copy.base_amplitude <= cfg_data[AMP_W-1:0];
                    CFG_OCTAVE_COUNT:   cfg_copy.octave_count   <= cfg_data[OCT_W-1:0];
                    CFG_FREQUENCY_STEP: cfg_copy.frequency_step <= cfg_data[FSTEP_W-1:0];
                    CFG_AMPLITUDE_STEP: cfg_copy.amplitude_step <= cfg_data[ASTEP_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (command == CMD_LOAD)
                    perm_copy[perm_index] = perm_value;
                else
                    expected_noise.push_back(fbm_noise(longint'(coord_x), longint'(coord_z)));
            end
            if (result_valid)
            begin
                if (expected_noise.size() == 0)
                begin
                    $display("%0t: unexpected result noise_value=%0d degenerate=%0b",
                             $time, noise_value, degenerate);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_noise.pop_front();
                    if (noise_value !== exp_r.noise || degenerate !== exp_r.degen)
                    begin
                        if (noise_value !== exp_r.noise)
                            $display("%0t: noise_value expected %0d actual %0d",
                                     $time, exp_r.noise, noise_value);
                        if (degenerate !== exp_r.degen)
                            $display("%0t: degenerate expected %0b actual %0b",
                                     $time, exp_r.degen, degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/simplex_noise_2d_octaves_test.sv @@
// Testbench top for the octave simplex noise block: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module simplex_noise_2d_octaves_test;
    import sno_pkg::*;

    localparam int                   CYCLE_LIMIT   = 2000000;
    localparam int                   DRAIN_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG    = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    cmd_t                         command = CMD_LOAD;
    logic [PERM_W-1:0]            perm_index = '0;
    logic [PERM_W-1:0]            perm_value = '0;
    logic signed [COORD_BITS-1:0] coord_x = '0;
    logic signed [COORD_BITS-1:0] coord_z = '0;
    logic                         result_valid;
    logic [NOISE_W-1:0]           noise_value;
    logic                         degenerate;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    int                           fail_count;
    int                           pending;
    int                           cycles = 0;
    bit                           gaps_on = 1'b1;

    simplex_noise_2d_octaves uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .perm_index(perm_index), .perm_value(perm_value), .coord_x(coord_x),
        .coord_z(coord_z), .result_valid(result_valid), .noise_value(noise_value),
        .degenerate(degenerate), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sno_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .perm_index(perm_index), .perm_value(perm_value), .coord_x(coord_x),
        .coord_z(coord_z), .result_valid(result_valid), .noise_value(noise_value),
        .degenerate(degenerate), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
        .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic issue(cmd_t cmd, logic [PERM_W-1:0] idx, logic [PERM_W-1:0] val,
                         logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] z);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        perm_index <= idx;
        perm_value <= val;
        coord_x    <= x;
        coord_z    <= z;
        do @(posedge clk); while (busy);
    endtask

    task automatic evaluate(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] z);
        issue(CMD_EVAL, PERM_W'($urandom), PERM_W'($urandom), x, z);
    endtask

    // Hold until the block has drained, then allow queued loads to retire
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(logic [31:0] bf, logic [31:0] ba, logic [31:0] oc,
                             logic [31:0] fs, logic [31:0] as_step);
        wait_drained();
        write_reg(CFG_BASE_FREQUENCY, bf);
        write_reg(CFG_BASE_AMPLITUDE, ba);
        write_reg(CFG_OCTAVE_COUNT, oc);
        write_reg(CFG_FREQUENCY_STEP, fs);
        write_reg(CFG_AMPLITUDE_STEP, as_step);
    endtask

    task automatic random_items(int n);
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] z;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 6) == 0)
                issue(CMD_LOAD, PERM_W'($urandom), PERM_W'($urandom), '0, '0);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    x = $urandom;
                    z = $urandom;
                end
                else
                begin
                    // mostly points within a few lattice cells of the origin
                    x = $urandom_range(0, 32'h00200000) - 32'h00100000;
                    z = $urandom_range(0, 32'h00200000) - 32'h00100000;
                end
                evaluate(x, z);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table before any evaluation reads it
        for (int k = 0; k < PERM_ENTRIES; k++)
            issue(CMD_LOAD, PERM_W'(k), PERM_W'($urandom), '0, '0);
        issue(CMD_LOAD, 8'd0, 8'd255, '0, '0);
        issue(CMD_LOAD, 8'd255, 8'd0, '0, '0);

        set_phase(32'h01000000, 32'h00010000, 32'd2, 32'h02000000, 32'h00008000);
        write_reg(CFG_NO_REG, 32'hFFFFFFFF);
        evaluate(32'h00000000, 32'h00000000);
        evaluate(32'h7FFFFFFF, 32'h7FFFFFFF);
        evaluate(32'h80000000, 32'h80000000);
        evaluate(32'h7FFFFFFF, 32'h80000000);
        evaluate(32'h80000000, 32'h7FFFFFFF);
        evaluate(32'hFFFFFFFF, 32'h00000000);
        evaluate(32'h00018000, 32'h00008000);
        evaluate(32'h00008000, 32'h00018000);
        evaluate(32'hFFFE8000, 32'hFFFF8000);

        set_phase(32'h01000000, 32'h00010000, 32'd4, 32'h02000000, 32'h00008000);
        random_items(50);
        // let every outstanding result arrive before sending more
        wait_drained();
        random_items(10);

        set_phase(32'h00100000, 32'h00010000, 32'd8, 32'h07FFFFFF, 32'h0003FFFF);
        random_items(30);

        set_phase(32'hFFFFFFFF, 32'h03FFFFFF, 32'd15, 32'h00000000, 32'h00000000);
        random_items(30);

        set_phase(32'h01000000, 32'h00010000, 32'd0, 32'h05000000, 32'h00020000);
        random_items(15);

        set_phase(32'h00800000, 32'h00000000, 32'd3, 32'h02000000, 32'h00008000);
        random_items(15);

        set_phase(32'h00000000, 32'h00004000, 32'd5, 32'h03000000, 32'h00010000);
        random_items(30);

        set_phase(32'h01800000, 32'h00010000, 32'd3, 32'h02000000, 32'h00008000);
        random_items(30);
        gaps_on = 1'b0;
        random_items(60);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
